// ===== src/pbc_pkg.sv =====
// Package for the bone pose composer: payload structs, constants, state codes
// and element helpers. It has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pbc_pkg;

    localparam int MAX_BONES = 256;
    localparam int FRAC_BITS = 8;
    localparam int BONE_W    = $clog2(MAX_BONES);
    localparam int ROW_AW    = BONE_W + 2;
    localparam int OPD_W     = 17;
    localparam int PROD_W    = 2 * OPD_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int CNT_W     = 5;

    localparam logic CFG_RATE   = 1'b0;
    localparam logic CFG_MARGIN = 1'b1;

    localparam logic OP_COMPOSE = 1'b0;
    localparam logic OP_ATTACH  = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [7:0]  bone_index;
        logic        has_parent;
        logic [7:0]  parent_index;
        logic        part_root;
        logic        use_rate;
        logic [63:0] row_zero;
        logic [63:0] row_one;
        logic [63:0] row_two;
        logic [63:0] row_three;
    } t_in;

    typedef struct packed {
        logic [7:0]  result_bone;
        logic [63:0] out_row_zero;
        logic [63:0] out_row_one;
        logic [63:0] out_row_two;
        logic [63:0] out_row_three;
    } t_out;

    typedef struct packed {
        logic [3:0][OPD_W-1:0] a;
        logic [3:0][OPD_W-1:0] b;
    } t_mac_op;

    typedef struct packed {
        logic       vld;
        logic [3:0] idx;
        logic       mrg;
    } t_tag;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_MUL,
        S_RATE,
        S_WR,
        S_DONE
    } t_state;

    function automatic logic [15:0] f_elem(input logic [63:0] row, input logic [1:0] j);
        return row[{j, 4'b0000} +: 16];
    endfunction

    function automatic logic [63:0] f_ident_row(input logic [1:0] i);
        logic [63:0] row;
        row = '0;
        row[{i, 4'b0000} +: 16] = 16'(1 << FRAC_BITS);
        return row;
    endfunction

    function automatic logic [OPD_W-1:0] f_sext(input logic [15:0] e);
        return {e[15], e};
    endfunction

endpackage

`default_nettype wire

// ===== src/bone_pose_composer_unit.sv =====
// Bone pose composer top: sequencer, matrix registers, bone table. Uses pbc_pkg, pbc_ram, pbc_mac.
// Elements go one per cycle through the shared multiplier unit; table rows move one per RAM cycle.
// One item at a time: a new item is accepted only when idle, and output stalls hold the done state.
// Reset (synchronous): every bone and the attach matrix read as identity, rate 1.0, margin 0;
// bone table uses per-bone valid bits, so no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module bone_pose_composer_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire pbc_pkg::t_in  i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output pbc_pkg::t_out      o_out,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_idx,
    input  wire logic [15:0]   i_cfg_data
);
    import pbc_pkg::*;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_cnt;
    t_in                  r_item;
    logic                 r_pvalid;
    logic [63:0]          r_par [4];
    logic [63:0]          r_att [4];
    logic [63:0]          r_res [4];
    logic [MAX_BONES-1:0] r_vld;
    logic [15:0]          r_rate;
    logic [15:0]          r_margin;
    t_tag                 r_tag;
    logic                 r_rd_vld;
    logic [1:0]           r_rd_row;
    logic                 r_ovld;
    t_out                 r_out;

    logic                 s_acc, s_ok;
    logic                 s_issue, s_rd, s_we, s_oload, s_mrg;
    logic [3:0]           s_idx;
    logic [ROW_AW-1:0]    s_raddr, s_waddr;
    t_mac_op              s_op;
    logic [15:0]          s_mac_res;
    logic [15:0]          s_cap;
    logic signed [16:0]   s_dif;
    logic [63:0]          s_rdata;
    logic [63:0]          s_loc [4];

    assign s_loc[0] = r_item.row_zero;
    assign s_loc[1] = r_item.row_one;
    assign s_loc[2] = r_item.row_two;
    assign s_loc[3] = r_item.row_three;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovld;
    assign o_out       = r_out;

    assign s_acc = i_in_valid && (r_state == S_IDLE);
    assign s_ok  = (i_in.operation == OP_COMPOSE)
                && (int'(i_in.bone_index) < MAX_BONES)
                && (!i_in.has_parent || (int'(i_in.parent_index) < MAX_BONES));

    pbc_ram #(
        .WIDTH(64),
        .DEPTH(MAX_BONES * 4)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (s_we),
        .i_waddr(s_waddr),
        .i_wdata(r_res[r_cnt[1:0]]),
        .i_raddr(s_raddr),
        .o_rdata(s_rdata)
    );

    pbc_mac u_mac (
        .i_clk(i_clk),
        .i_op (s_op),
        .o_res(s_mac_res)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_acc && s_ok) begin
                    if (i_in.has_parent) begin
                        n_state = S_RD;
                    end else if (i_in.part_root) begin
                        n_state = S_MUL;
                    end else begin
                        n_state = S_WR;
                    end
                end
            end
            S_RD: begin
                if (r_cnt == CNT_W'(4)) n_state = S_MUL;
            end
            S_MUL: begin
                if (r_cnt == CNT_W'(16)) begin
                    n_state = (r_item.part_root && !r_item.has_parent && r_item.use_rate)
                            ? S_RATE : S_WR;
                end
            end
            S_RATE: begin
                if (r_cnt == CNT_W'(3)) n_state = S_WR;
            end
            S_WR: begin
                if (r_cnt == CNT_W'(3)) n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovld || !i_out_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_issue = 1'b0;
        s_rd    = 1'b0;
        s_we    = 1'b0;
        s_oload = 1'b0;
        s_mrg   = 1'b0;
        s_idx   = r_cnt[3:0];
        s_raddr = {r_item.parent_index[BONE_W-1:0], r_cnt[1:0]};
        s_waddr = {r_item.bone_index[BONE_W-1:0], r_cnt[1:0]};
        s_op    = '0;
        unique case (r_state)
            S_RD: begin
                s_rd = (r_cnt < CNT_W'(4));
            end
            S_MUL: begin
                s_issue = (r_cnt < CNT_W'(16));
                for (int k = 0; k < 4; k++) begin
                    s_op.a[k] = f_sext(f_elem(s_loc[r_cnt[3:2]], 2'(k)));
                    s_op.b[k] = f_sext(f_elem(r_par[k], r_cnt[1:0]));
                end
            end
            S_RATE: begin
                s_issue   = (r_cnt < CNT_W'(3));
                s_idx     = {2'b11, r_cnt[1:0]};
                s_mrg     = (r_cnt == CNT_W'(1));
                s_op.a[0] = f_sext(f_elem(r_res[3], r_cnt[1:0]));
                s_op.b[0] = {1'b0, r_rate};
            end
            S_WR: begin
                s_we = 1'b1;
            end
            S_DONE: begin
                s_oload = !r_ovld || !i_out_stall;
            end
            S_IDLE: begin
            end
            default: begin
            end
        endcase
    end

    // margin applied to the vertical element after rate rounding
    always_comb begin
        s_dif = {s_mac_res[15], s_mac_res} - {r_margin[15], r_margin};
        if (!r_tag.mrg) begin
            s_cap = s_mac_res;
        end else if (s_dif > 17'sd32767) begin
            s_cap = 16'h7FFF;
        end else if (s_dif < -17'sd32768) begin
            s_cap = 16'h8000;
        end else begin
            s_cap = s_dif[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_vld    <= '0;
            r_rate   <= 16'(1 << FRAC_BITS);
            r_margin <= '0;
            r_tag    <= '0;
            r_rd_vld <= 1'b0;
            r_ovld   <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_att[i] <= f_ident_row(2'(i));
            end
        end else begin
            r_state <= n_state;
            r_cnt   <= (n_state != r_state || r_state == S_IDLE) ? '0 : r_cnt + 1'b1;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_RATE:   r_rate   <= i_cfg_data;
                    CFG_MARGIN: r_margin <= i_cfg_data;
                    default: ;
                endcase
            end

            if (s_acc && i_in.operation == OP_ATTACH) begin
                r_att[0] <= i_in.row_zero;
                r_att[1] <= i_in.row_one;
                r_att[2] <= i_in.row_two;
                r_att[3] <= i_in.row_three;
            end

            r_tag    <= '{vld: s_issue, idx: s_idx, mrg: s_mrg};
            r_rd_vld <= s_rd;

            if (r_state == S_WR && r_cnt == CNT_W'(3)) begin
                r_vld[r_item.bone_index[BONE_W-1:0]] <= 1'b1;
            end

            if (s_oload) begin
                r_ovld <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_item   <= i_in;
            r_pvalid <= r_vld[i_in.parent_index[BONE_W-1:0]];
            if (!i_in.has_parent && i_in.part_root) begin
                for (int i = 0; i < 4; i++) begin
                    r_par[i] <= r_att[i];
                end
            end
            if (!i_in.has_parent && !i_in.part_root) begin
                r_res[0] <= i_in.row_zero;
                r_res[1] <= i_in.row_one;
                r_res[2] <= i_in.row_two;
                r_res[3] <= i_in.row_three;
            end
        end
        r_rd_row <= r_cnt[1:0];
        if (r_rd_vld) begin
            r_par[r_rd_row] <= r_pvalid ? s_rdata : f_ident_row(r_rd_row);
        end
        if (r_tag.vld) begin
            r_res[r_tag.idx[3:2]][{r_tag.idx[1:0], 4'b0000} +: 16] <= s_cap;
        end
        if (s_oload) begin
            r_out <= '{result_bone:   r_item.bone_index,
                       out_row_zero:  r_res[0],
                       out_row_one:   r_res[1],
                       out_row_two:   r_res[2],
                       out_row_three: r_res[3]};
        end
    end

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside done state");

    a_compose_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && s_ok) |=> (r_state != S_IDLE))
        else $error("accepted compose did not start");

    a_no_mac_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_WR) |-> !r_tag.vld)
        else $error("multiplier result pending outside compute states");

    a_write_in_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_we |-> (r_state == S_WR) && !r_rd_vld)
        else $error("table write overlaps read");

endmodule

`default_nettype wire

// ===== src/pbc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pbc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== src/pbc_mac.sv =====
// Shared four-multiplier dot-product unit: registered products, then sum,
// round half up and saturate to 16 bits. Uses pbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pbc_mac (
    input  wire logic             i_clk,
    input  wire pbc_pkg::t_mac_op i_op,
    output logic [15:0]           o_res
);
    import pbc_pkg::*;

    logic signed [PROD_W-1:0] r_prod [4];
    logic signed [SUM_W-1:0]  s_sum;
    logic signed [SUM_W-1:0]  s_shf;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_prod[k] <= $signed(i_op.a[k]) * $signed(i_op.b[k]);
        end
    end

    always_comb begin
        s_sum = SUM_W'(r_prod[0]) + SUM_W'(r_prod[1]) + SUM_W'(r_prod[2])
              + SUM_W'(r_prod[3]) + SUM_W'(1 << (FRAC_BITS - 1));
        s_shf = s_sum >>> FRAC_BITS;
        if (s_shf > SUM_W'(32767)) begin
            o_res = 16'h7FFF;
        end else if (s_shf < -SUM_W'(32768)) begin
            o_res = 16'h8000;
        end else begin
            o_res = s_shf[15:0];
        end
    end

endmodule

`default_nettype wire

// ===== tb/bone_pose_composer_unit_tb.sv =====
// Self-checking testbench for bone_pose_composer_unit: directed table, then random
// bone hierarchies checked against an in-bench pose predictor. Depends on pbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bone_pose_composer_unit_tb;
    import pbc_pkg::*;

    typedef logic [3:0][63:0] mat_t;

    typedef struct {
        t_in  item;
        bit   typed;
        t_out pose;
    } row_t;

    localparam longint LIMIT = 3000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in         i_in = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out        o_out;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = CFG_RATE;
    logic [15:0] i_cfg_data = '0;

    bone_pose_composer_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    mat_t        pose_tbl [MAX_BONES];
    mat_t        attach_mat;
    logic [15:0] rate_q88;
    logic [15:0] margin_q88;
    t_out        pose_q [$];
    row_t        table_rows [$];
    int          errors = 0;
    int          sent = 0;
    int          poses_seen = 0;
    longint      cycles = 0;
    byte unsigned recent [$];

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("MISMATCH %s: got %h want %h (pose %0d)", what, got, want, poses_seen);
        errors++;
    endtask

    function automatic longint elem(input logic [63:0] r, input int j);
        return longint'($signed(r[16*j +: 16]));
    endfunction

    function automatic longint sat16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint round_q(input longint v);
        return sat16((v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
    endfunction

    function automatic mat_t compose(input mat_t l, input mat_t p);
        mat_t   c;
        longint acc;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) begin
                acc = 0;
                for (int k = 0; k < 4; k++) acc += elem(l[i], k) * elem(p[k], j);
                c[i][16*j +: 16] = 16'(round_q(acc));
            end
        return c;
    endfunction

    function automatic mat_t ident();
        mat_t m;
        for (int i = 0; i < 4; i++) m[i] = 64'(16'(1 << FRAC_BITS)) << (16 * i);
        return m;
    endfunction

    // Returns 1 and the pose when the item produces a transfer.
    function automatic bit predict_pose(input t_in x, output t_out y);
        mat_t   l, c;
        longint e [3];
        l = {x.row_three, x.row_two, x.row_one, x.row_zero};
        y = '0;
        if (x.operation == OP_ATTACH) begin
            attach_mat = l;
            return 0;
        end
        if (x.bone_index >= MAX_BONES) return 0;
        if (x.has_parent && x.parent_index >= MAX_BONES) return 0;
        if (!x.has_parent && x.part_root) begin
            c = compose(l, attach_mat);
            if (x.use_rate) begin
                for (int i = 0; i < 3; i++)
                    e[i] = round_q(elem(c[3], i) * longint'(rate_q88));
                e[1] = sat16(e[1] - longint'($signed(margin_q88)));
                for (int i = 0; i < 3; i++) c[3][16*i +: 16] = 16'(e[i]);
            end
        end else if (!x.has_parent) begin
            c = l;
        end else begin
            c = compose(l, pose_tbl[x.parent_index]);
        end
        pose_tbl[x.bone_index] = c;
        y.result_bone   = x.bone_index;
        y.out_row_zero  = c[0];
        y.out_row_one   = c[1];
        y.out_row_two   = c[2];
        y.out_row_three = c[3];
        return 1;
    endfunction

    // Receiver: checks each transfer and applies random backpressure.
    int  hold_left = 0;
    int  quiet_left = 0;
    bit  held_long = 0;
    always @(posedge i_clk) begin
        t_out w;
        int   r;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                poses_seen++;
                if (pose_q.size() == 0) begin
                    report("unexpected transfer", 64'(o_out.result_bone), '0);
                end else begin
                    w = pose_q.pop_front();
                    if (o_out.result_bone !== w.result_bone)
                        report("result_bone", 64'(o_out.result_bone), 64'(w.result_bone));
                    if (o_out.out_row_zero !== w.out_row_zero)
                        report("out_row_zero", o_out.out_row_zero, w.out_row_zero);
                    if (o_out.out_row_one !== w.out_row_one)
                        report("out_row_one", o_out.out_row_one, w.out_row_one);
                    if (o_out.out_row_two !== w.out_row_two)
                        report("out_row_two", o_out.out_row_two, w.out_row_two);
                    if (o_out.out_row_three !== w.out_row_three)
                        report("out_row_three", o_out.out_row_three, w.out_row_three);
                end
            end
            r = $urandom_range(0, 31);
            if (!held_long && poses_seen == 60) begin
                held_long = 1;
                hold_left = 400;
                i_out_stall <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (quiet_left > 0) begin
                quiet_left--;
                i_out_stall <= 1'b0;
            end else if (r < 18) begin
                i_out_stall <= 1'b0;
            end else if (r < 28) begin
                i_out_stall <= 1'b1;
            end else if (r < 30) begin
                hold_left = $urandom_range(10, 60);
                i_out_stall <= 1'b1;
            end else begin
                quiet_left = $urandom_range(20, 120);
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send(input t_in x, input int gap, input bit typed, input t_out pose);
        t_out y;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= x;
        do @(posedge i_clk); while (o_in_stall);
        sent++;
        if (predict_pose(x, y)) pose_q.push_back(typed ? pose : y);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pose_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        if (idx == CFG_RATE) rate_q88 = d; else margin_q88 = d;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 9) return 0;
        if (r < 18) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [15:0] rand_elem();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2, 3: return 16'($urandom);
            4: return 16'(1 << FRAC_BITS);
            default: return 16'($signed($urandom_range(0, 1024)) - 512);
        endcase
    endfunction

    function automatic logic [63:0] rand_row();
        return {rand_elem(), rand_elem(), rand_elem(), rand_elem()};
    endfunction

    function automatic t_in rand_item();
        t_in x;
        x.operation    = ($urandom_range(0, 9) == 0) ? OP_ATTACH : OP_COMPOSE;
        x.bone_index   = 8'($urandom);
        x.has_parent   = ($urandom_range(0, 9) < 6);
        x.parent_index = 8'($urandom);
        if (recent.size() != 0 && $urandom_range(0, 1))
            x.parent_index = recent[$urandom_range(0, recent.size() - 1)];
        if ($urandom_range(0, 19) == 0) x.parent_index = x.bone_index;
        x.part_root    = ($urandom_range(0, 9) < 3);
        x.use_rate     = $urandom_range(0, 1);
        x.row_zero     = rand_row();
        x.row_one      = rand_row();
        x.row_two      = rand_row();
        x.row_three    = rand_row();
        return x;
    endfunction

    function automatic t_in mk(input logic op, input byte unsigned bone, input bit hp,
                               input byte unsigned par, input bit root, input bit rt,
                               input mat_t m);
        t_in x;
        x = '{operation: op, bone_index: bone, has_parent: hp, parent_index: par,
              part_root: root, use_rate: rt, row_zero: m[0], row_one: m[1],
              row_two: m[2], row_three: m[3]};
        return x;
    endfunction

    function automatic t_out as_pose(input byte unsigned bone, input mat_t m);
        t_out y;
        y = '{result_bone: bone, out_row_zero: m[0], out_row_one: m[1],
              out_row_two: m[2], out_row_three: m[3]};
        return y;
    endfunction

    task automatic add_row(input t_in x, input bit typed, input mat_t m);
        row_t r;
        r.item  = x;
        r.typed = typed;
        r.pose  = as_pose(x.bone_index, m);
        table_rows.push_back(r);
    endtask

    initial begin
        mat_t ext, loc, zero, ones;
        t_in  x;
        t_out none;
        logic [15:0] rates [4];
        logic [15:0] margins [4];

        ext  = {64'h7FFF_8000_7FFF_8000, 64'h8000_7FFF_8000_7FFF,
                64'h7FFF_7FFF_8000_8000, 64'h8000_8000_7FFF_7FFF};
        loc  = {64'h0A00_FE80_0300_0100, 64'h0000_0100_0080_FF00,
                64'h0000_FFC0_0100_0040, 64'h0100_0000_0000_0000};
        zero = '0;
        ones = {4{64'hFFFF_FFFF_FFFF_FFFF}};
        none = '0;
        for (int b = 0; b < MAX_BONES; b++) pose_tbl[b] = ident();
        attach_mat = ident();
        rate_q88   = 16'd256;
        margin_q88 = 16'd0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(mk(OP_COMPOSE, 0, 0, 0, 0, 0, ext), 1, ext);
        add_row(mk(OP_COMPOSE, 1, 1, 200, 0, 0, loc), 1, loc);
        add_row(mk(OP_COMPOSE, 2, 0, 0, 1, 0, loc), 1, loc);
        add_row(mk(OP_COMPOSE, 3, 0, 0, 1, 1, loc), 1, loc);
        add_row(mk(OP_COMPOSE, 8, 1, 250, 0, 1, loc), 1, loc);
        add_row(mk(OP_COMPOSE, 255, 0, 0, 0, 0, zero), 1, zero);
        add_row(mk(OP_COMPOSE, 254, 0, 0, 0, 1, ones), 1, ones);
        add_row(mk(OP_ATTACH, 9, 1, 3, 1, 1, ext), 0, zero);
        add_row(mk(OP_COMPOSE, 4, 0, 0, 1, 0, loc), 0, zero);
        add_row(mk(OP_COMPOSE, 5, 0, 0, 1, 1, loc), 0, zero);
        add_row(mk(OP_COMPOSE, 6, 1, 0, 0, 0, loc), 0, zero);
        add_row(mk(OP_COMPOSE, 6, 1, 6, 0, 0, ext), 0, zero);
        add_row(mk(OP_COMPOSE, 7, 1, 4, 1, 1, loc), 0, zero);
        add_row(mk(OP_COMPOSE, 9, 1, 255, 0, 0, ext), 0, zero);
        add_row(mk(OP_COMPOSE, 10, 1, 254, 0, 0, ext), 0, zero);
        add_row(mk(OP_ATTACH, 0, 0, 0, 0, 0, loc), 0, zero);
        add_row(mk(OP_COMPOSE, 11, 0, 0, 1, 1, ext), 0, zero);
        foreach (table_rows[i])
            send(table_rows[i].item, pick_gap(), table_rows[i].typed, table_rows[i].pose);
        drain();

        rates   = '{16'hFFFF, 16'h0000, 16'h0180, 16'($urandom)};
        margins = '{16'h8000, 16'h7FFF, 16'h0040, 16'($urandom)};
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_RATE, rates[ph]);
            write_reg(CFG_MARGIN, margins[ph]);
            for (int n = 0; n < 470; n++) begin
                x = rand_item();
                send(x, pick_gap(), 0, none);
                if (x.operation == OP_COMPOSE) begin
                    recent.push_back(x.bone_index);
                    if (recent.size() > 8) void'(recent.pop_front());
                end
            end
            drain();
        end

        $display("Covered %0d transfers in, %0d poses out, 4 rate/margin settings",
                 sent, poses_seen);
        $display("including attach loads, self parents, saturation and long stalls");
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/pbc_pkg.sv
src/pbc_ram.sv
src/pbc_mac.sv
src/bone_pose_composer_unit.sv
tb/bone_pose_composer_unit_tb.sv
